// ----- hdl/rv32_pkg.sv -----
// rv32_pkg: shared types, opcodes and codes for the rv32i execute core
// no dependencies
`default_nettype none

package rv32_pkg;

  localparam int unsigned XLEN        = 32;
  localparam int unsigned NumRegsDef  = 32;
  localparam int unsigned RegIdxW     = 5;

  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpFence  = 7'h0f;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpJal    = 7'h6f;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [1:0] MemNone  = 2'd0;
  localparam logic [1:0] MemLoad  = 2'd1;
  localparam logic [1:0] MemStore = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatIllegal = 2'd1;
  localparam logic [1:0] StatNoLoad  = 2'd2;

  localparam logic [6:0] Funct7Alt = 7'h20;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic [1:0]  access_size;
    logic [31:0] write_data;
    logic [31:0] mem_address;
    logic [1:0]  mem_kind;
  } result_t;

  typedef enum logic [1:0] {
    ST_READ = 2'b01,
    ST_EXEC = 2'b10
  } phase_e;

  function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                     input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    case (f3)
      3'd0: r = alt ? a - b : a + b;
      3'd1: r = a << b[4:0];
      3'd2: r = {31'd0, $signed(a) < $signed(b)};
      3'd3: r = {31'd0, a < b};
      3'd4: r = a ^ b;
      3'd5: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6: r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rv32_ram.sv -----
// rv32_ram: generic single-write dual-read ram, registered read
// no dependencies
`default_nettype none

module rv32_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- hdl/rv32i_instruction_execute_core.sv -----
// rv32i_instruction_execute_core: rv32i execute core with ram register file
// depends on rv32_pkg and rv32_ram
//
// channel  dir  tdata bits                 tuser
// s_axis   in   [31:0] payload             [0] req_type
// m_axis   out  [1:0] kind [33:2] addr [65:34] wdata [67:66] size [99:68] npc
//              [101:100] status (104 bits)
//
// each item passes a register file read, then execute and write-back
// items overlap, so one is taken each cycle while results are taken
// reset clears the register file with a pass over all 32 entries (one entry a cycle)
// a stalled output register holds the result; the next item may still be read
`default_nettype none

module rv32i_instruction_execute_core
  import rv32_pkg::*;
#(
  parameter int unsigned NumRegs = NumRegsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [31:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // payload
  input  wire logic [0:0]   s_axis_tuser,   // req_type
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [103:0] m_axis_tdata    // kind,addr,wdata,size,npc,status; pad
);

  localparam int unsigned AddrW = RegIdxW;

  logic         clr_q, clr_d;
  logic [AddrW:0] clr_cnt_q, clr_cnt_d;
  logic         busy_q, busy_d;
  logic         ltype_q, ltype_d;
  logic [31:0]  x_q, x_d;
  logic [31:0]  pc_q, pc_d;
  logic         lp_q, lp_d;
  logic [4:0]   ldst_q, ldst_d;
  logic [2:0]   lkind_q, lkind_d;
  logic         ov_q, ov_d;
  result_t      res_q, res_d;

  logic         we;
  logic [4:0]   waddr;
  logic [31:0]  wdata;
  logic [31:0]  ra, rb;
  logic [4:0]   raddr_a, raddr_b;

  logic in_xfer, exec, out_free;
  assign out_free      = !ov_q || m_axis_tready;
  assign exec          = busy_q && out_free;
  assign s_axis_tready = !clr_q && (!busy_q || exec);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // a waiting item keeps its own operands on the read port
  assign raddr_a = in_xfer ? s_axis_tdata[19:15] : x_q[19:15];
  assign raddr_b = in_xfer ? s_axis_tdata[24:20] : x_q[24:20];

  rv32_ram #(.Width(32), .Depth(32)) u_rf (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(ra),
    .rdata_b_o(rb)
  );

  // decode
  logic [6:0] op, f7;
  logic [4:0] rd, rs1, rs2;
  logic [2:0] f3;
  logic [31:0] a, b, immi, imms, immb, immj, alu_b, pc4;
  logic fwd_a, fwd_b;
  logic [31:0] ex_wdata;
  logic        ex_we;
  logic        taken;
  result_t     r;

  assign op  = x_q[6:0];
  assign rd  = x_q[11:7];
  assign f3  = x_q[14:12];
  assign rs1 = x_q[19:15];
  assign rs2 = x_q[24:20];
  assign f7  = x_q[31:25];
  assign immi = {{20{x_q[31]}}, x_q[31:20]};
  assign imms = {{20{x_q[31]}}, x_q[31:25], x_q[11:7]};
  assign immb = {{20{x_q[31]}}, x_q[7], x_q[30:25], x_q[11:8], 1'b0};
  assign immj = {{12{x_q[31]}}, x_q[19:12], x_q[20], x_q[30:21], 1'b0};
  assign pc4  = pc_q + 32'd4;

  // forwarding register from the write of the previous item
  logic        fw_v_q, fw_v_d;
  logic [4:0]  fw_a_q, fw_a_d;
  logic [31:0] fw_d_q, fw_d_d;

  always_comb begin
    fwd_a = fw_v_q && fw_a_q == rs1;
    fwd_b = fw_v_q && fw_a_q == rs2;
    a = (rs1 == 5'd0 || 32'(rs1) >= NumRegs) ? 32'd0 : (fwd_a ? fw_d_q : ra);
    b = (rs2 == 5'd0 || 32'(rs2) >= NumRegs) ? 32'd0 : (fwd_b ? fw_d_q : rb);
  end

  always_comb begin
    r = '0;
    r.next_pc = pc4;
    r.status = StatOk;
    ex_we = 1'b0;
    ex_wdata = '0;
    taken = 1'b0;
    alu_b = immi;
    lp_d = lp_q;
    ldst_d = ldst_q;
    lkind_d = lkind_q;
    if (ltype_q) begin
      r.next_pc = pc_q;
      if (!lp_q) begin
        r.status = StatNoLoad;
      end else begin
        ex_we = 1'b1;
        case (lkind_q)
          3'd0: ex_wdata = {{24{x_q[7]}}, x_q[7:0]};
          3'd1: ex_wdata = {{16{x_q[15]}}, x_q[15:0]};
          3'd4: ex_wdata = {24'd0, x_q[7:0]};
          3'd5: ex_wdata = {16'd0, x_q[15:0]};
          default: ex_wdata = x_q;
        endcase
        lp_d = 1'b0;
      end
    end else begin
      lp_d = 1'b0;
      case (op)
        OpLoad: begin
          if (f3 == 3'd3 || f3 >= 3'd6) r.status = StatIllegal;
          else begin
            r.mem_kind = MemLoad;
            r.mem_address = a + immi;
            r.access_size = f3[1:0];
            lp_d = 1'b1;
            ldst_d = rd;
            lkind_d = f3;
          end
        end
        OpFence: if (f3 != 3'd0) r.status = StatIllegal;
        OpImm: begin
          if ((f3 == 3'd1 && f7 != 7'd0) ||
              (f3 == 3'd5 && f7 != 7'd0 && f7 != Funct7Alt)) r.status = StatIllegal;
          else begin
            ex_we = 1'b1;
            ex_wdata = alu(f3, f3 == 3'd5 && x_q[30], a, immi);
          end
        end
        OpAuipc: begin ex_we = 1'b1; ex_wdata = {x_q[31:12], 12'd0} + pc_q; end
        OpStore: begin
          if (f3 > 3'd2) r.status = StatIllegal;
          else begin
            r.mem_kind = MemStore;
            r.mem_address = a + imms;
            r.write_data = b;
            r.access_size = f3[1:0];
          end
        end
        OpReg: begin
          if (f7 != 7'd0 && !(f7 == Funct7Alt && (f3 == 3'd0 || f3 == 3'd5)))
            r.status = StatIllegal;
          else begin
            ex_we = 1'b1;
            alu_b = b;
            ex_wdata = alu(f3, f7 == Funct7Alt, a, alu_b);
          end
        end
        OpLui: begin ex_we = 1'b1; ex_wdata = {x_q[31:12], 12'd0}; end
        OpBranch: begin
          case (f3)
            3'd0: taken = a == b;
            3'd1: taken = a != b;
            3'd4: taken = $signed(a) < $signed(b);
            3'd5: taken = !($signed(a) < $signed(b));
            3'd6: taken = a < b;
            3'd7: taken = a >= b;
            default: r.status = StatIllegal;
          endcase
          if (taken) r.next_pc = pc_q + immb;
        end
        OpJalr: begin
          if (f3 != 3'd0) r.status = StatIllegal;
          else begin
            r.next_pc = (a + immi) & 32'hffff_fffe;
            ex_we = 1'b1; ex_wdata = pc4;
          end
        end
        OpJal: begin r.next_pc = pc_q + immj; ex_we = 1'b1; ex_wdata = pc4; end
        OpSystem: begin
          if (f3 != 3'd0 || rd != 5'd0 || rs1 != 5'd0 || x_q[31:20] > 12'd1)
            r.status = StatIllegal;
        end
        default: r.status = StatIllegal;
      endcase
    end
  end

  logic [4:0] ex_dst;
  logic       ex_wr;
  assign ex_dst = ltype_q ? ldst_q : rd;
  assign ex_wr  = exec && ex_we && ex_dst != 5'd0 && 32'(ex_dst) < NumRegs;

  always_comb begin
    clr_d = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == (AddrW+1)'(31)) clr_d = 1'b0;
    end
    we    = clr_q || ex_wr;
    waddr = clr_q ? clr_cnt_q[AddrW-1:0] : ex_dst;
    wdata = clr_q ? 32'd0 : ex_wdata;

    busy_d = in_xfer ? 1'b1 : (exec ? 1'b0 : busy_q);
    x_d     = in_xfer ? s_axis_tdata : x_q;
    ltype_d = in_xfer ? s_axis_tuser[0] : ltype_q;
    // forward only when the write lands in the cycle the next item reads
    fw_v_d = in_xfer ? ex_wr : fw_v_q && !in_xfer;
    fw_a_d = in_xfer ? ex_dst : fw_a_q;
    fw_d_d = in_xfer ? ex_wdata : fw_d_q;
    if (!in_xfer) begin
      fw_v_d = fw_v_q; fw_a_d = fw_a_q; fw_d_d = fw_d_q;
    end

    ov_d  = exec ? 1'b1 : (m_axis_tready ? 1'b0 : ov_q);
    res_d = exec ? r : res_q;
    pc_d  = exec ? r.next_pc : pc_q;
    if (cfg_we_i) pc_d = cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1; clr_cnt_q <= '0; busy_q <= 1'b0; ov_q <= 1'b0;
      pc_q <= '0; lp_q <= 1'b0; ldst_q <= '0; lkind_q <= '0; fw_v_q <= 1'b0;
    end else begin
      clr_q <= clr_d; clr_cnt_q <= clr_cnt_d; busy_q <= busy_d; ov_q <= ov_d;
      pc_q <= pc_d; fw_v_q <= fw_v_d;
      if (exec) begin lp_q <= lp_d; ldst_q <= ldst_d; lkind_q <= lkind_d; end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; ltype_q <= ltype_d; res_q <= res_d; fw_a_q <= fw_a_d; fw_d_q <= fw_d_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, res_q};

  a_no_accept_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready) else $error("transfer taken during clear");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !m_axis_tready |-> !exec) else $error("result overwritten");
  a_exec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |-> busy_q && !clr_q) else $error("execute without item");
endmodule

`default_nettype wire

// ----- tb/rv32i_instruction_execute_core_chk.sv -----
// rv32i_instruction_execute_core_chk: predicts and checks the execute core results
// watches both stream channels and the config port; depends on rv32_pkg
`default_nettype none

module rv32i_instruction_execute_core_chk
  import rv32_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [31:0]  cfg_wdata_i,
  input  wire logic         s_valid_i,
  input  wire logic         s_ready_i,
  input  wire logic [31:0]  s_data_i,
  input  wire logic [0:0]   s_user_i,
  input  wire logic         m_valid_i,
  input  wire logic         m_ready_i,
  input  wire logic [103:0] m_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                seen_o
);

  logic [31:0] gpr [32];
  logic [31:0] pc_q;
  logic        ld_busy;
  logic [4:0]  ld_rd;
  logic [2:0]  ld_f3;
  result_t     exp_q [$];

  function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
    logic [31:0] m;
    m = 32'h1 << (bits - 1);
    if (bits < 32) v = v & ((32'h1 << bits) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic logic [31:0] exec_alu(input logic [2:0] f3, input logic alt,
                                          input logic [31:0] a, input logic [31:0] b);
    case (f3)
      3'd0: return alt ? a - b : a + b;
      3'd1: return a << b[4:0];
      3'd2: return {31'd0, $signed(a) < $signed(b)};
      3'd3: return {31'd0, a < b};
      3'd4: return a ^ b;
      3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6: return a | b;
      default: return a & b;
    endcase
  endfunction

  task automatic wr_gpr(input logic [4:0] idx, input logic [31:0] v);
    if (idx != 5'd0) gpr[idx] = v;
  endtask

  task automatic execute_item(input logic rt, input logic [31:0] x);
    result_t r;
    logic [6:0] op, f7;
    logic [4:0] rd, rs1;
    logic [2:0] f3;
    logic [31:0] a, b, immi, imms, immb, immj, v;
    logic tk;
    r = '0;
    r.next_pc = pc_q + 32'd4;
    if (rt) begin
      r.next_pc = pc_q;
      if (!ld_busy) begin
        r.status = StatNoLoad;
      end else begin
        case (ld_f3)
          3'd0: v = sx(x, 8);
          3'd1: v = sx(x, 16);
          3'd4: v = x & 32'hff;
          3'd5: v = x & 32'hffff;
          default: v = x;
        endcase
        wr_gpr(ld_rd, v);
        ld_busy = 1'b0;
      end
    end else begin
      op = x[6:0]; rd = x[11:7]; f3 = x[14:12]; rs1 = x[19:15]; f7 = x[31:25];
      a = gpr[rs1]; b = gpr[x[24:20]];
      immi = sx(x >> 20, 12);
      imms = sx({20'd0, f7, rd}, 12);
      immb = sx({19'd0, x[31], x[7], x[30:25], x[11:8], 1'b0}, 13);
      immj = sx({11'd0, x[31], x[19:12], x[20], x[30:21], 1'b0}, 21);
      tk = 1'b0;
      ld_busy = 1'b0;
      case (op)
        OpLoad: begin
          if (f3 == 3'd3 || f3 >= 3'd6) r.status = StatIllegal;
          else begin
            r.mem_kind = MemLoad; r.mem_address = a + immi; r.access_size = {1'b0, f3[1]} | f3[1:0];
            r.access_size = f3[1:0];
            ld_busy = 1'b1; ld_rd = rd; ld_f3 = f3;
          end
        end
        OpFence: if (f3 != 3'd0) r.status = StatIllegal;
        OpImm: begin
          if ((f3 == 3'd1 && f7 != 7'd0) ||
              (f3 == 3'd5 && f7 != 7'd0 && f7 != Funct7Alt)) r.status = StatIllegal;
          else wr_gpr(rd, exec_alu(f3, f3 == 3'd5 && x[30], a, immi));
        end
        OpAuipc: wr_gpr(rd, (x & 32'hfffff000) + pc_q);
        OpStore: begin
          if (f3 > 3'd2) r.status = StatIllegal;
          else begin
            r.mem_kind = MemStore; r.mem_address = a + imms;
            r.write_data = b; r.access_size = f3[1:0];
          end
        end
        OpReg: begin
          if (f7 != 7'd0 && !(f7 == Funct7Alt && (f3 == 3'd0 || f3 == 3'd5)))
            r.status = StatIllegal;
          else wr_gpr(rd, exec_alu(f3, f7 == Funct7Alt, a, b));
        end
        OpLui: wr_gpr(rd, x & 32'hfffff000);
        OpBranch: begin
          case (f3)
            3'd0: tk = a == b;
            3'd1: tk = a != b;
            3'd4: tk = $signed(a) < $signed(b);
            3'd5: tk = $signed(a) >= $signed(b);
            3'd6: tk = a < b;
            3'd7: tk = a >= b;
            default: r.status = StatIllegal;
          endcase
          if (tk) r.next_pc = pc_q + immb;
        end
        OpJalr: begin
          if (f3 != 3'd0) r.status = StatIllegal;
          else begin
            r.next_pc = (a + immi) & 32'hfffffffe;
            wr_gpr(rd, pc_q + 32'd4);
          end
        end
        OpJal: begin
          r.next_pc = pc_q + immj;
          wr_gpr(rd, pc_q + 32'd4);
        end
        OpSystem:
          if (f3 != 3'd0 || rd != 5'd0 || rs1 != 5'd0 || (x >> 20) > 32'd1)
            r.status = StatIllegal;
        default: r.status = StatIllegal;
      endcase
      pc_q = r.next_pc;
    end
    exp_q.push_back(r);
  endtask

  assign pending_o = exp_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      foreach (gpr[i]) gpr[i] = '0;
      pc_q = '0; ld_busy = 1'b0; ld_rd = '0; ld_f3 = '0;
      exp_q.delete();
      fail_count_o = 0;
      seen_o = 0;
    end else begin
      if (cfg_we_i) pc_q = cfg_wdata_i;
      if (m_valid_i && m_ready_i) begin
        got = m_data_i[101:0];
        seen_o++;
        if (exp_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected transfer: %h", got);
        end else begin
          want = exp_q.pop_front();
          if (got !== want || m_data_i[103:102] !== 2'b00) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: exp kind %0d addr %h wd %h sz %0d npc %h st %0d / got kind %0d addr %h wd %h sz %0d npc %h st %0d",
                       want.mem_kind, want.mem_address, want.write_data, want.access_size,
                       want.next_pc, want.status, got.mem_kind, got.mem_address,
                       got.write_data, got.access_size, got.next_pc, got.status);
          end
        end
      end
      if (s_valid_i && s_ready_i) execute_item(s_user_i[0], s_data_i);
    end
  end

endmodule

`default_nettype wire

// ----- tb/rv32i_instruction_execute_core_tb.sv -----
// rv32i_instruction_execute_core_tb: stimulus and verdict for the rv32i execute core
// depends on rv32_pkg, rv32i_instruction_execute_core and its checker module
`default_nettype none

module rv32i_instruction_execute_core_tb;
  import rv32_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  int           fails, pending, seen, sent;
  bit           stim_done = 1'b0;

  always #4 clk_i = ~clk_i;

  rv32i_instruction_execute_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  rv32i_instruction_execute_core_chk u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .fail_count_o(fails), .pending_o(pending), .seen_o(seen)
  );

  // receiver stall pattern
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
      repeat (gap) @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // called at a falling edge; tvalid stays high into the next transfer when there is no gap
  task automatic send(input logic rt, input logic [31:0] w, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rt;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rnd_legal();
    logic [31:0] w;
    logic [6:0] ops [11];
    ops = '{OpLoad, OpFence, OpImm, OpAuipc, OpStore, OpReg, OpLui, OpBranch,
            OpJalr, OpJal, OpSystem};
    w = $urandom();
    w[6:0] = ops[$urandom_range(0, 10)];
    // bias register indexes towards a few so values get reused
    if ($urandom_range(0, 1)) w[19:15] = 5'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) w[24:20] = 5'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) w[11:7]  = 5'($urandom_range(0, 7));
    case (w[6:0])
      OpLoad:   if (w[14:12] == 3'd3 || w[14:12] >= 3'd6) w[14:12] = 3'd2;
      OpStore:  w[14:12] = 3'($urandom_range(0, 2));
      OpFence, OpJalr: w[14:12] = 3'd0;
      OpReg:    w[31:25] = (w[14:12] == 3'd0 || w[14:12] == 3'd5) && w[30] ?
                           Funct7Alt : 7'd0;
      OpImm:    if (w[14:12] == 3'd1) w[31:25] = 7'd0;
                else if (w[14:12] == 3'd5) w[31:25] = w[30] ? Funct7Alt : 7'd0;
      OpSystem: w = {11'd0, w[20], 20'd0} | {25'd0, OpSystem};
      default: ;
    endcase
    return w;
  endfunction

  task automatic run_random(input int n);
    logic [31:0] w;
    bit burst;
    for (int i = 0; i < n; i++) begin
      burst = ($urandom_range(0, 99) < 60) && (i % 64 < 20);
      if ($urandom_range(0, 9) == 0) w = $urandom();
      else w = rnd_legal();
      send(1'b0, w, burst);
      if (w[6:0] == OpLoad && $urandom_range(0, 7) != 0) send(1'b1, $urandom(), burst);
      else if ($urandom_range(0, 30) == 0) send(1'b1, $urandom(), burst);
    end
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_start(input logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] dir [$];
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass of the register file
    repeat (40) @(negedge clk_i);
    set_start(32'hffff_fff0);
    dir = '{32'h8000_0093, 32'h7ff0_0113, 32'hfff0_0193, 32'h4011_5213,
            32'h0011_5293, 32'h4031_0333, 32'h0031_73b3, 32'h0031_2433,
            32'h0031_34b3, 32'hfe31_4ee3, 32'h0031_7463, 32'h8000_00b7,
            32'h0000_1517, 32'h0080_056f, 32'h0001_05e7, 32'h0000_0073,
            32'h0010_0073, 32'h0000_000f, 32'h0031_2023, 32'hfff0_8603,
            32'h0001_4683, 32'h0000_0000, 32'hffff_ffff, 32'h0200_0033};
    foreach (dir[i]) begin
      send(1'b0, dir[i], 1'b0);
      if (dir[i][6:0] == OpLoad) send(1'b1, 32'h0000_8f80, 1'b0);
    end
    send(1'b1, 32'hffff_ffff, 1'b0);
    quiesce();
    set_start(32'h0000_0000);
    run_random(500);
    quiesce();
    set_start(32'hffff_ffff);
    run_random(200);
    quiesce();
    set_start($urandom());
    run_random(700);
    quiesce();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("covered %0d input transfers and %0d result transfers over four start pcs",
             sent, seen);
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/rv32_pkg.sv
hdl/rv32_ram.sv
hdl/rv32i_instruction_execute_core.sv
tb/rv32i_instruction_execute_core_chk.sv
tb/rv32i_instruction_execute_core_tb.sv
